/* rtl/core/vfo_pkg.sv */
// vfo_pkg: shared types, constants and the control store for the voxel face occlusion block
// no dependencies; imported by vfo_seq, vfo_dp and the top level, not by vfo_ram

package vfo_pkg;

	// default volume dimensions
	localparam int unsigned DEF_SIZE_X = 16;
	localparam int unsigned DEF_SIZE_Y = 64;
	localparam int unsigned DEF_SIZE_Z = 16;

	// coordinate width inside the datapath: holds any size up to 256 plus one step either way
	localparam int unsigned CRD_W = 9;

	// step counter width
	localparam int unsigned PC_W = 4;

	// command codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// voxel entry bits
	localparam int unsigned VOX_AIR_BIT = 0;
	localparam int unsigned VOX_OPQ_BIT = 1;
	localparam int unsigned VOX_W = 2;

	// face bit positions
	localparam logic [2:0] FACE_XP = 3'd0;
	localparam logic [2:0] FACE_XN = 3'd1;
	localparam logic [2:0] FACE_YP = 3'd2;
	localparam logic [2:0] FACE_YN = 3'd3;
	localparam logic [2:0] FACE_ZP = 3'd4;
	localparam logic [2:0] FACE_ZN = 3'd5;

	// program labels
	localparam logic [PC_W-1:0] PC_ENTRY = 4'd0;
	localparam logic [PC_W-1:0] PC_SCAN  = 4'd8;
	localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;
	localparam logic [PC_W-1:0] PC_WRITE = 4'd10;

	// input beat
	typedef struct packed {
		logic       mode;
		logic [3:0] pos_x;
		logic [5:0] pos_y;
		logic [3:0] pos_z;
		logic       is_air;
		logic       opaque;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [5:0] face_mask;
		logic       sky_shadowed;
	} result_t;

	// which voxel the address generator points at
	typedef enum logic [2:0] {
		SEL_CTR,
		SEL_XP,
		SEL_XN,
		SEL_YP,
		SEL_YN,
		SEL_ZP,
		SEL_ZN,
		SEL_COL
	} sel_t;

	// where the read data of the previous step goes
	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_CTR,
		CAP_FACE,
		CAP_SKY
	} cap_t;

	// sequencing of the step counter
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_IF_WRITE,
		JMP_IF_MORE,
		JMP_END
	} jmp_t;

	// one control word
	typedef struct packed {
		logic            rd;
		sel_t            sel;
		cap_t            cap;
		logic [2:0]      face;
		logic            wr;
		logic            emit;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic is_write;
		logic scan_more;
	} stat_t;

	localparam ctrl_t CTRL_IDLE = '{
		rd: 1'b0, sel: SEL_CTR, cap: CAP_NONE, face: FACE_XP,
		wr: 1'b0, emit: 1'b0, jmp: JMP_END, target: PC_ENTRY
	};

	// control store
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = CTRL_IDLE;
		unique case (pc)
			4'd0: begin
				// read the addressed voxel, branch off for writes
				w.rd = 1'b1; w.sel = SEL_CTR;
				w.jmp = JMP_IF_WRITE; w.target = PC_WRITE;
			end
			4'd1: begin
				w.rd = 1'b1; w.sel = SEL_XP; w.cap = CAP_CTR; w.jmp = JMP_NEXT;
			end
			4'd2: begin
				w.rd = 1'b1; w.sel = SEL_XN; w.cap = CAP_FACE; w.face = FACE_XP;
				w.jmp = JMP_NEXT;
			end
			4'd3: begin
				w.rd = 1'b1; w.sel = SEL_YP; w.cap = CAP_FACE; w.face = FACE_XN;
				w.jmp = JMP_NEXT;
			end
			4'd4: begin
				w.rd = 1'b1; w.sel = SEL_YN; w.cap = CAP_FACE; w.face = FACE_YP;
				w.jmp = JMP_NEXT;
			end
			4'd5: begin
				w.rd = 1'b1; w.sel = SEL_ZP; w.cap = CAP_FACE; w.face = FACE_YN;
				w.jmp = JMP_NEXT;
			end
			4'd6: begin
				w.rd = 1'b1; w.sel = SEL_ZN; w.cap = CAP_FACE; w.face = FACE_ZP;
				w.jmp = JMP_NEXT;
			end
			4'd7: begin
				// first column read goes out with the last face capture
				w.rd = 1'b1; w.sel = SEL_COL; w.cap = CAP_FACE; w.face = FACE_ZN;
				w.jmp = JMP_NEXT;
			end
			4'd8: begin
				// column scan loop
				w.rd = 1'b1; w.sel = SEL_COL; w.cap = CAP_SKY;
				w.jmp = JMP_IF_MORE; w.target = PC_SCAN;
			end
			4'd9: begin
				w.emit = 1'b1; w.jmp = JMP_END;
			end
			4'd10: begin
				w.wr = 1'b1; w.sel = SEL_CTR; w.jmp = JMP_END;
			end
			default: begin
				w = CTRL_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/vfo_ram.sv */
// vfo_ram: generic single write port, single read port ram with registered read data
// no dependencies

module vfo_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/vfo_seq.sv */
// vfo_seq: step counter and control store lookup that drive the datapath
// depends on vfo_pkg

module vfo_seq import vfo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	logic            run_q;
	logic [PC_W-1:0] pc_q;

	// current control word, idle word while stopped
	always_comb begin
		ctrl = run_q ? ucode(pc_q) : CTRL_IDLE;
	end

	assign busy = run_q;

	// step counter with conditional jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= PC_ENTRY;
		end else if (accept) begin
			run_q <= 1'b1;
			pc_q  <= PC_ENTRY;
		end else if (run_q) begin
			unique case (ctrl.jmp)
				JMP_NEXT:     pc_q  <= pc_q + PC_W'(1);
				JMP_IF_WRITE: pc_q  <= stat.is_write ? ctrl.target : pc_q + PC_W'(1);
				JMP_IF_MORE:  pc_q  <= stat.scan_more ? ctrl.target : pc_q + PC_W'(1);
				JMP_END:      run_q <= 1'b0;
				default:      run_q <= 1'b0;
			endcase
		end
	end

endmodule

/* rtl/core/vfo_dp.sv */
// vfo_dp: coordinate registers, address generation, capture of read data and result register
// depends on vfo_pkg; drives the voxel ram ports

module vfo_dp import vfo_pkg::*; #(
	parameter int unsigned SIZE_X = DEF_SIZE_X,
	parameter int unsigned SIZE_Y = DEF_SIZE_Y,
	parameter int unsigned SIZE_Z = DEF_SIZE_Z,
	parameter int unsigned AW     = $clog2(SIZE_X * SIZE_Y * SIZE_Z)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  cmd_t             cmd,
	input  ctrl_t            ctrl,
	output stat_t            stat,
	output logic             mem_we,
	output logic [AW-1:0]    mem_addr_w,
	output logic [VOX_W-1:0] mem_wdata,
	output logic [AW-1:0]    mem_addr_r,
	input  logic [VOX_W-1:0] mem_rdata,
	output logic             result_valid,
	output result_t          result
);

	logic [CRD_W-1:0] x_q, y_q, z_q, scan_q;
	logic             mode_q, air_q, opq_q;
	logic [VOX_W-1:0] ctr_q;
	logic [5:0]       face_q;
	logic             sky_q;
	logic             rv_s1;
	result_t          result_q;
	logic             result_valid_q;

	logic [CRD_W-1:0] ax, ay, az;
	logic             inb;
	logic [AW-1:0]    row, addr;
	logic [5:0]       mask_fin;
	logic             found, skip;

	// address generator: pick the voxel of this step
	always_comb begin
		ax = x_q;
		ay = y_q;
		az = z_q;
		unique case (ctrl.sel)
			SEL_CTR: ;
			SEL_XP:  ax = x_q + CRD_W'(1);
			SEL_XN:  ax = x_q - CRD_W'(1);
			SEL_YP:  ay = y_q + CRD_W'(1);
			SEL_YN:  ay = y_q - CRD_W'(1);
			SEL_ZP:  az = z_q + CRD_W'(1);
			SEL_ZN:  az = z_q - CRD_W'(1);
			SEL_COL: ay = scan_q;
			default: ;
		endcase
	end

	// bounds check; a step below zero wraps far past any size
	assign inb = (ax < CRD_W'(SIZE_X)) && (ay < CRD_W'(SIZE_Y)) && (az < CRD_W'(SIZE_Z));

	// linear address x + SIZE_X * (y + SIZE_Y * z)
	assign row  = AW'(ay) + AW'(SIZE_Y) * AW'(az);
	assign addr = AW'(ax) + AW'(SIZE_X) * row;

	assign mem_addr_r = addr;
	assign mem_addr_w = addr;
	assign mem_we     = ctrl.wr & inb;
	assign mem_wdata  = {opq_q, air_q};

	// face mask from the center voxel and the captured neighbours
	always_comb begin
		if (!ctr_q[VOX_OPQ_BIT]) begin
			mask_fin = 6'h00;
		end else if (ctr_q[VOX_AIR_BIT]) begin
			mask_fin = 6'h3f;
		end else begin
			mask_fin = face_q;
		end
	end

	// read data of the previous step, valid only when that voxel was inside
	assign found = rv_s1 & mem_rdata[VOX_OPQ_BIT];
	assign skip  = mask_fin[FACE_YP];

	assign stat.is_write  = (mode_q == MODE_WRITE);
	assign stat.scan_more = rv_s1 & ~found & ~skip;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rv_s1          <= ctrl.rd & inb;
			result_valid_q <= ctrl.emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= CRD_W'(cmd.pos_x);
			y_q    <= CRD_W'(cmd.pos_y);
			z_q    <= CRD_W'(cmd.pos_z);
			scan_q <= CRD_W'(cmd.pos_y) + CRD_W'(1);
			mode_q <= cmd.mode;
			air_q  <= cmd.is_air;
			opq_q  <= cmd.opaque;
			ctr_q  <= '0;
			face_q <= '0;
			sky_q  <= 1'b0;
		end else begin
			if (ctrl.rd && (ctrl.sel == SEL_COL)) begin
				scan_q <= scan_q + CRD_W'(1);
			end
			case (ctrl.cap)
				CAP_CTR:  ctr_q <= rv_s1 ? mem_rdata : '0;
				CAP_FACE: face_q[ctrl.face] <= found;
				CAP_SKY:  sky_q <= sky_q | (found & ~skip);
				default:  ;
			endcase
		end
		if (ctrl.emit) begin
			result_q.face_mask    <= mask_fin;
			result_q.sky_shadowed <= sky_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/voxel_face_occlusion.sv */
// voxel_face_occlusion: top level, voxel store with face culling and sky occlusion queries
// depends on vfo_pkg, vfo_ram, vfo_seq, vfo_dp
//
// Usage: present a command on cmd and raise start; the beat is taken at a clock edge where
// start is high and busy is low. mode 0 writes the voxel at (pos_x, pos_y, pos_z) with its
// is_air and opaque bits and gives no result. mode 1 queries that voxel and gives one result
// beat: result_valid is high for exactly one cycle with face_mask and sky_shadowed on result.
// The receiver cannot stall; it must take the beat in that cycle.
// A write runs the entry step, which reads the voxel, and then the write step. A query
// reads the voxel and its six neighbours, then scans the column above one voxel per cycle,
// stopping at the first opaque one, when the +y face is covered, or at the top; busy stays
// high until the program ends, and the result beat follows in the cycle busy falls, when a
// new command can already be taken. The voxel ram has a single read port, so each step of
// the control program reads at most one voxel.
// Reset clears the sequencer, the read valid flag and the result strobe only; the voxel store is not cleared and
// a voxel must be written before any query reads it.

module voxel_face_occlusion import vfo_pkg::*; #(
	parameter int unsigned SIZE_X = DEF_SIZE_X,
	parameter int unsigned SIZE_Y = DEF_SIZE_Y,
	parameter int unsigned SIZE_Z = DEF_SIZE_Z
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	localparam int unsigned DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic             accept;
	ctrl_t            ctrl;
	stat_t            stat;
	logic             mem_we;
	logic [AW-1:0]    mem_addr_w, mem_addr_r;
	logic [VOX_W-1:0] mem_wdata, mem_rdata;

	assign accept = start & ~busy;

	// control program sequencer
	vfo_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// datapath
	vfo_dp #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z),
		.AW     (AW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.ctrl         (ctrl),
		.stat         (stat),
		.mem_we       (mem_we),
		.mem_addr_w   (mem_addr_w),
		.mem_wdata    (mem_wdata),
		.mem_addr_r   (mem_addr_r),
		.mem_rdata    (mem_rdata),
		.result_valid (result_valid),
		.result       (result)
	);

	// voxel store
	vfo_ram #(
		.WIDTH (VOX_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr_w),
		.wdata (mem_wdata),
		.raddr (mem_addr_r),
		.rdata (mem_rdata)
	);

	// an accepted command always occupies the sequencer next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer not running after accepted beat");

	// the result beat only appears once the program has finished
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result beat while program still running");

	// a result strobe lasts one cycle
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// sky shadow is never reported with the +y face covered
	a_sky_face: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sky_shadowed |-> !result.face_mask[FACE_YP])
		else $error("sky shadow reported with top face covered");

	// writes only happen while the program runs
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("voxel write outside a running program");

endmodule
